@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ src/iirbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirbp_pkg
// types, widths and coefficient tables of the order-12 band-pass iir filter
// ----------------------------------------------------------------------------
package iirbp_pkg;

  localparam int FILTER_ORDER = 12;
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 24;
  localparam int COEF_W       = 32;
  localparam int HIST_W       = 48;
  localparam int OPND_W       = FRAC_BITS + 1;
  localparam int PROD_W       = COEF_W + OPND_W;
  localparam int ACC_W        = 64;
  localparam int TAP_W        = $clog2(FILTER_ORDER + 1);
  localparam int RND_W        = ACC_W - FRAC_BITS;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [HIST_W-1:0]       HIST_MAX   = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0]       HIST_MIN   = {1'b1, {(HIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MAC_ADD,
    MAC_SUB_HI,
    MAC_SUB_LO
  } mac_op_e;

  typedef struct packed {
    logic    clear;
    logic    issue;
    mac_op_e op;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           record_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;
  } out_item_t;

  // feedback coefficients, q7.24
  function automatic logic signed [COEF_W-1:0] coef_a(input logic [TAP_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      4'd1:    c = -32'sd116873442;
      4'd2:    c =  32'sd373373587;
      4'd3:    c = -32'sd732484862;
      4'd4:    c =  32'sd995179155;
      4'd5:    c = -32'sd994543298;
      4'd6:    c =  32'sd750706596;
      4'd7:    c = -32'sd430050378;
      4'd8:    c =  32'sd185252341;
      4'd9:    c = -32'sd58567583;
      4'd10:   c =  32'sd12864769;
      4'd11:   c = -32'sd1748186;
      4'd12:   c =  32'sd114085;
      default: c =  32'sd16777216;
    endcase
    return c;
  endfunction

  // feed-forward coefficients, q7.24
  function automatic logic signed [COEF_W-1:0] coef_b(input logic [TAP_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      4'd0, 4'd12: c =  32'sd135895;
      4'd2, 4'd10: c = -32'sd812017;
      4'd4, 4'd8:  c =  32'sd2031721;
      4'd6:        c = -32'sd2709520;
      default:     c =  32'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ src/iir_bandpass_order12_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_bandpass_order12_unit
// order-12 band-pass iir filter, direct form i, one shared multiplier
// ----------------------------------------------------------------------------
// One 16-bit sample in, one rounded and saturated 16-bit sample out. A single
// 32x25 multiplier feeds an accumulator: 13 feed-forward products and two
// products per feedback tap (high and low halves of the q.24 history) make 37
// products in ST_RUN, ST_DRAIN drains the product register, and ST_FINISH
// rounds, saturates and shifts the histories once the output register is free
// or being read, and in_ready_o returns in the same cycle as out_valid_o.
// A finished result waits in the output register while the next sample runs.
// record_start clears both histories before its sample is used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iir_bandpass_order12_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  iirbp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output iirbp_pkg::out_item_t out_data_o
);
  import iirbp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(FILTER_ORDER);

  logic [1:0]                     state_q, state_d;
  logic                           b_phase_q;
  logic                           half_q;
  logic [TAP_W-1:0]               tap_q;
  logic [TAP_W-1:0]               hidx;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] in_hist_q  [FILTER_ORDER];
  logic signed [HIST_W-1:0]       out_hist_q [FILTER_ORDER];
  logic signed [SAMPLE_WIDTH-1:0] x_sel;
  logic signed [HIST_W-1:0]       y_sel;
  logic signed [COEF_W-1:0]       coef;
  logic signed [OPND_W-1:0]       opnd;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_rnd;
  logic signed [RND_W-1:0]        rounded;
  logic signed [HIST_W-1:0]       y_new;
  logic                           acc_ovf;
  logic                           rnd_ovf;
  logic                           in_fire;
  logic                           last_step;
  logic                           commit;
  logic                           out_valid_q;
  out_item_t                      out_q;
  mac_ctrl_t                      mac_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_step  = !b_phase_q && half_q && (tap_q == LAST_TAP);
  assign commit     = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_RUN;
      ST_RUN:    if (last_step) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      b_phase_q <= 1'b1;
      half_q    <= 1'b0;
      tap_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        b_phase_q <= 1'b1;
        half_q    <= 1'b0;
        tap_q     <= '0;
      end else if (state_q == ST_RUN) begin
        if (b_phase_q) begin
          if (tap_q == LAST_TAP) begin
            b_phase_q <= 1'b0;
            tap_q     <= TAP_W'(1);
          end else begin
            tap_q <= tap_q + TAP_W'(1);
          end
        end else if (half_q) begin
          half_q <= 1'b0;
          if (tap_q != LAST_TAP) tap_q <= tap_q + TAP_W'(1);
        end else begin
          half_q <= 1'b1;
        end
      end
    end
  end

  // operand selection
  assign hidx  = tap_q - TAP_W'(1);
  assign x_sel = (tap_q == '0) ? x_q : in_hist_q[hidx];
  assign y_sel = out_hist_q[hidx];
  assign coef  = b_phase_q ? coef_b(tap_q) : coef_a(tap_q);

  always_comb begin
    if (b_phase_q) begin
      opnd = {{(OPND_W-SAMPLE_WIDTH){x_sel[SAMPLE_WIDTH-1]}}, x_sel};
    end else if (half_q) begin
      opnd = {1'b0, y_sel[FRAC_BITS-1:0]};
    end else begin
      opnd = {y_sel[HIST_W-1], y_sel[HIST_W-1:FRAC_BITS]};
    end
  end

  always_comb begin
    mac_ctrl.clear = in_fire;
    mac_ctrl.issue = (state_q == ST_RUN);
    if (b_phase_q) mac_ctrl.op = MAC_ADD;
    else if (half_q) mac_ctrl.op = MAC_SUB_LO;
    else mac_ctrl.op = MAC_SUB_HI;
  end

  iirbp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef),
    .opnd_i (opnd),
    .acc_o  (acc)
  );

  // history saturation and output rounding
  assign acc_ovf = (acc[ACC_W-1:HIST_W-1] != {(ACC_W-HIST_W+1){1'b0}}) &&
                   (acc[ACC_W-1:HIST_W-1] != {(ACC_W-HIST_W+1){1'b1}});
  assign y_new   = acc_ovf ? (acc[ACC_W-1] ? HIST_MIN : HIST_MAX) : acc[HIST_W-1:0];
  assign acc_rnd = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign rounded = acc_rnd[ACC_W-1:FRAC_BITS];
  assign rnd_ovf = (rounded[RND_W-1:SAMPLE_WIDTH-1] != {(RND_W-SAMPLE_WIDTH+1){1'b0}}) &&
                   (rounded[RND_W-1:SAMPLE_WIDTH-1] != {(RND_W-SAMPLE_WIDTH+1){1'b1}});

  // sample and histories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FILTER_ORDER; i++) begin
        in_hist_q[i]  <= '0;
        out_hist_q[i] <= '0;
      end
    end else if (in_fire && in_data_i.record_start) begin
      for (int i = 0; i < FILTER_ORDER; i++) begin
        in_hist_q[i]  <= '0;
        out_hist_q[i] <= '0;
      end
    end else if (commit) begin
      for (int i = FILTER_ORDER - 1; i > 0; i--) begin
        in_hist_q[i]  <= in_hist_q[i-1];
        out_hist_q[i] <= out_hist_q[i-1];
      end
      in_hist_q[0]  <= x_q;
      out_hist_q[0] <= y_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) x_q <= in_data_i.sample_in;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.clipped    <= rnd_ovf;
      out_q.sample_out <= rnd_ovf ? (rounded[RND_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                                  : rounded[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_accept_starts_run, clk_i, rst_ni, in_fire |=> (state_q == ST_RUN) && b_phase_q && (tap_q == '0))
  `ASSERT_NEVER_CLK(a_no_accept_while_busy, clk_i, rst_ni, in_ready_o && (state_q != ST_IDLE))
  `ASSERT_CLK(a_clip_at_rail, clk_i, rst_ni, (out_valid_o && out_data_o.clipped) |-> ((out_data_o.sample_out == SAMPLE_MAX) || (out_data_o.sample_out == SAMPLE_MIN)))
  `ASSERT_CLK(a_commit_gives_output, clk_i, rst_ni, commit |=> out_valid_o && (state_q == ST_IDLE))

endmodule

@@ src/iirbp_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirbp_mac
// shared multiplier with registered product and 64-bit accumulator
// ----------------------------------------------------------------------------
module iirbp_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  iirbp_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [iirbp_pkg::COEF_W-1:0]     coef_i,
  input  logic signed [iirbp_pkg::OPND_W-1:0]     opnd_i,
  output logic signed [iirbp_pkg::ACC_W-1:0]      acc_o
);
  import iirbp_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] prod_lo;
  logic signed [PROD_W-1:0] prod_sel;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  mac_op_e                  op_q;
  logic                     vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      op_q  <= MAC_ADD;
    end else if (ctrl_i.clear) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctrl_i.issue;
      op_q  <= ctrl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= coef_i * opnd_i;
    end
  end

  // low half: round half up back to q.24
  assign prod_rnd = prod_q + (PROD_W'(1) <<< (FRAC_BITS - 1));
  assign prod_lo  = prod_rnd >>> FRAC_BITS;
  assign prod_sel = (op_q == MAC_SUB_LO) ? prod_lo : prod_q;
  assign term     = {{(ACC_W-PROD_W){prod_sel[PROD_W-1]}}, prod_sel};

  always_comb begin
    acc_d = acc_q;
    if (vld_q) begin
      unique case (op_q)
        MAC_ADD:    acc_d = acc_q + term;
        MAC_SUB_HI: acc_d = acc_q - term;
        MAC_SUB_LO: acc_d = acc_q - term;
        default:    acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the order-12 band-pass iir filter unit
// ----------------------------------------------------------------------------
// A table of hand-picked samples runs first: reset state, full-scale steps,
// record restarts, bit patterns and a full-scale square wave. The random part
// then sends records of noise, square tones, low-level signal and peak values,
// some of them long, with stray restarts. Every accepted sample goes through
// a bit-exact fixed-point filter model in the bench, and each output
// transaction is compared with the oldest pending prediction. Both sides stall
// at random, the receiver holds off once for a long stretch, and the sender
// stops now and then until all pending results have returned.
// ----------------------------------------------------------------------------
module tb_top;

  import iirbp_pkg::*;

  localparam int     DIRECTED_ROWS = 25;
  localparam int     RANDOM_ITEMS  = 600;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     TAPS          = 12;
  localparam longint ROUND_HALF    = 64'sd8388608;
  localparam longint Y_MAX         = 64'sd140737488355327;
  localparam longint Y_MIN         = -Y_MAX - 64'sd1;
  localparam longint S_MAX         = 64'sd32767;
  localparam longint S_MIN         = -64'sd32768;

  localparam longint FB_COEF [13] = '{
    16777216, -116873442, 373373587, -732484862, 995179155, -994543298,
    750706596, -430050378, 185252341, -58567583, 12864769, -1748186, 114085
  };
  localparam longint FF_COEF [13] = '{
    135895, 0, -812017, 0, 2031721, 0, -2709520, 0, 2031721, 0, -812017, 0, 135895
  };

  typedef enum int {
    REC_NOISE,
    REC_TONE,
    REC_QUIET,
    REC_PEAKS
  } rec_kind_e;

  typedef struct packed {
    in_item_t  stim;
    logic      pinned;
    out_item_t want;
  } row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  logic signed [15:0] x_hist [TAPS];
  logic signed [47:0] y_hist [TAPS];

  out_item_t filtered_q [$];
  row_t      dir_rows [DIRECTED_ROWS];
  bit        hold_req = 1'b0;
  int        err_count;
  int        samples_sent;
  int        records_started;
  int        clip_count;
  int        hist_clamp_count;
  int        drain_count;

  iir_bandpass_order12_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("iir_bandpass_order12_unit verification failed");
    $finish;
  end

  // bit-exact filter step, advances the bench copy of both histories
  function automatic out_item_t filter_next_sample(input in_item_t s);
    longint    acc;
    longint    yv;
    longint    yh;
    longint    yl;
    longint    rnd;
    out_item_t r;
    if (s.record_start) begin
      for (int j = 0; j < TAPS; j++) begin
        x_hist[j] = '0;
        y_hist[j] = '0;
      end
    end
    acc = FF_COEF[0] * longint'(s.sample_in);
    for (int j = 1; j <= TAPS; j++) begin
      acc += FF_COEF[j] * longint'(x_hist[j-1]);
      yv  = y_hist[j-1];
      yh  = yv >>> 24;
      yl  = yv - (yh <<< 24);
      acc -= FB_COEF[j] * yh + ((FB_COEF[j] * yl + ROUND_HALF) >>> 24);
    end
    for (int j = TAPS - 1; j > 0; j--) begin
      x_hist[j] = x_hist[j-1];
      y_hist[j] = y_hist[j-1];
    end
    x_hist[0] = s.sample_in;
    if (acc > Y_MAX) begin
      y_hist[0] = Y_MAX[47:0];
      hist_clamp_count++;
    end else if (acc < Y_MIN) begin
      y_hist[0] = Y_MIN[47:0];
      hist_clamp_count++;
    end else begin
      y_hist[0] = acc[47:0];
    end
    rnd = (acc + ROUND_HALF) >>> 24;
    r.clipped = 1'b0;
    if (rnd > S_MAX) begin
      rnd = S_MAX;
      r.clipped = 1'b1;
    end else if (rnd < S_MIN) begin
      rnd = S_MIN;
      r.clipped = 1'b1;
    end
    r.sample_out = rnd[15:0];
    if (r.clipped) clip_count++;
    return r;
  endfunction

  function automatic row_t mk_row(input logic [15:0] s, input logic st, input logic pin,
                                  input logic [15:0] w);
    row_t r;
    r.stim.sample_in    = s;
    r.stim.record_start = st;
    r.pinned            = pin;
    r.want.sample_out   = w;
    r.want.clipped      = 1'b0;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic int sender_gap();
    return ($urandom_range(0, 1) == 0) ? 0 : idle_len();
  endfunction

  task automatic offer(input in_item_t s, input int gap, input logic pin,
                       input out_item_t pin_val);
    out_item_t nxt;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    nxt = filter_next_sample(s);
    filtered_q.push_back(pin ? pin_val : nxt);
    samples_sent++;
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    drain_count++;
  endtask

  // output side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected output transaction, sample_out %0d clipped %0b",
                 $time, $signed(out_data_o.sample_out), out_data_o.clipped);
        err_count++;
      end else begin
        want = filtered_q.pop_front();
        if (out_data_o.sample_out !== want.sample_out) begin
          $display("%0t: sample_out mismatch, expected %0d actual %0d", $time,
                   $signed(want.sample_out), $signed(out_data_o.sample_out));
          err_count++;
        end
        if (out_data_o.clipped !== want.clipped) begin
          $display("%0t: clipped mismatch, expected %0b actual %0b", $time,
                   want.clipped, out_data_o.clipped);
          err_count++;
        end
      end
    end
  end

  initial begin
    in_item_t  s;
    rec_kind_e kind;
    int        len;
    int        hp;
    int        amp;
    int        val;
    bit        steady;

    for (int j = 0; j < TAPS; j++) begin
      x_hist[j] = '0;
      y_hist[j] = '0;
    end

    dir_rows = '{
      mk_row(16'h7FFF, 1'b0, 1'b1, 16'h0109),
      mk_row(16'h8000, 1'b1, 1'b1, 16'hFEF7),
      mk_row(16'h0000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h0000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h0001, 1'b1, 1'b1, 16'h0000),
      mk_row(16'hFFFF, 1'b1, 1'b1, 16'h0000),
      mk_row(16'h0000, 1'b1, 1'b1, 16'h0000),
      mk_row(16'h5555, 1'b0, 1'b0, 16'h0000),
      mk_row(16'hAAAA, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b1, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h7FFF, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000),
      mk_row(16'h8000, 1'b0, 1'b0, 16'h0000)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer(dir_rows[i].stim, sender_gap(), dir_rows[i].pinned, dir_rows[i].want);
    end
    drain_pending();

    while (samples_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      kind   = rec_kind_e'($urandom_range(0, 3));
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 250) : $urandom_range(8, 60);
      hp     = $urandom_range(1, 24);
      amp    = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 32767) : 32767;
      steady = ($urandom_range(0, 3) == 0);
      if (records_started % 5 == 4) drain_pending();
      if (records_started == 3) hold_req = 1'b1;
      for (int k = 0; k < len && samples_sent < DIRECTED_ROWS + RANDOM_ITEMS; k++) begin
        case (kind)
          REC_NOISE: val = $urandom_range(0, 65535);
          REC_TONE:  val = ((k / hp) % 2 == 0) ? amp : -amp - 1;
          REC_QUIET: val = $urandom_range(0, 64) - 32;
          default: begin
            case ($urandom_range(0, 4))
              0:       val = 32767;
              1:       val = -32768;
              2:       val = 1;
              3:       val = -1;
              default: val = 0;
            endcase
          end
        endcase
        s.sample_in    = val[15:0];
        s.record_start = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0);
        offer(s, (steady || hold_req) ? 0 : sender_gap(), 1'b0, '0);
      end
      records_started++;
    end

    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("ran %0d samples in %0d random records; %0d outputs saturated, %0d history clamps",
             samples_sent, records_started, clip_count, hist_clamp_count);
    $display("one %0d-cycle receiver hold-off under load, %0d full drains of the pipeline",
             HOLD_CYCLES, drain_count);
    if (err_count == 0 && filtered_q.size() == 0) begin
      $display("iir_bandpass_order12_unit verification clean");
    end else begin
      $display("iir_bandpass_order12_unit verification failed");
    end
    $finish;
  end

endmodule
